/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, cond)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* hdl/flkv_pkg.sv */
// ----------------------------------------------------------------------------
// flkv_pkg
// shared types and codes of the flash log key-value store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flkv_pkg;

   localparam logic [2:0] OP_GET  = 3'd0;
   localparam logic [2:0] OP_SET  = 3'd1;
   localparam logic [2:0] OP_DATA = 3'd2;
   localparam logic [2:0] OP_READ = 3'd3;
   localparam logic [2:0] OP_WIPE = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd2;
   localparam logic [1:0] STATUS_BAD_KEY   = 2'd3;

   localparam logic [15:0] END_KEY = 16'hFFFF;
   localparam logic [7:0]  ERASED  = 8'hFF;
   localparam logic [7:0]  PAD     = 8'h00;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] key;
      logic [11:0] length;
      logic [7:0]  data_byte;
      logic [11:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] value_address;
      logic [11:0] value_length;
      logic [7:0]  read_data;
   } rsp_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LATCH,
      DP_CLR_ALL_INIT,
      DP_CLR_SEC_INIT,
      DP_CLR_STEP,
      DP_ABORT_INIT,
      DP_ABORT_STEP,
      DP_ABORT_DONE,
      DP_PEND_LOAD,
      DP_DATA_WR,
      DP_W_APPEND,
      DP_W_COMPACT,
      DP_PAD_STEP,
      DP_HWR_STEP,
      DP_CPY_RD,
      DP_CPY_WR,
      DP_CWO_END,
      DP_CPT_NEXT,
      DP_APPEND_END,
      DP_CPT_INIT,
      DP_CPT_REC,
      DP_SCAN_INIT,
      DP_HRD_STEP,
      DP_SCAN_EVAL,
      DP_CPT_SWITCH,
      DP_RD_ISSUE,
      DP_RSP_READ,
      DP_RSP_GET,
      DP_RSP_OK,
      DP_RSP_NOSPACE,
      DP_RSP_BADKEY
   } dp_op_type;

   typedef struct packed {
      logic [2:0] op;
      logic       key_end;
      logic       data_more;
      logic       data_last;
      logic       abort_more;
      logic       fits;
      logic       len_zero;
      logic       pad_more;
      logic       cnt3;
      logic       cnt4;
      logic       cpy_more;
      logic       rec_ok;
      logic       keep;
      logic       clr_last;
   } dp_status_type;

endpackage

/* hdl/flkv_datapath.sv */
// ----------------------------------------------------------------------------
// flkv_datapath
// flash byte array, offsets, header buffer and response registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flkv_datapath #(
   parameter int SECTOR_BYTES = 4096,
   parameter int SECTOR_COUNT = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  flkv_pkg::dp_op_type     cmd,
   input  flkv_pkg::req_type       req_item,
   output flkv_pkg::dp_status_type st,
   output logic                    rsp_strobe,
   output flkv_pkg::rsp_type       rsp_item
);
   import flkv_pkg::*;

   localparam int OW    = $clog2(SECTOR_BYTES) + 1;
   localparam int CW    = ((OW > 16) ? OW : 16) + 2;
   localparam int TOTAL = SECTOR_BYTES * SECTOR_COUNT;
   localparam int AW    = $clog2(TOTAL);
   localparam int SW    = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
   localparam logic [CW-1:0] SB_C   = CW'(SECTOR_BYTES);
   localparam logic [CW-1:0] FOUR_C = CW'(4);

   logic [7:0] mem [TOTAL];

   req_type        rq_ff, rq_in;
   logic [SW-1:0]  active_ff, active_in;
   logic [OW-1:0]  append_ff, append_in;
   logic [15:0]    pkey_ff, pkey_in;
   logic [11:0]    plen_ff, plen_in;
   logic [11:0]    brx_ff, brx_in;
   logic [OW-1:0]  cro_ff, cro_in;
   logic [OW-1:0]  cwo_ff, cwo_in;
   logic [OW-1:0]  cn_ff, cn_in;
   logic [OW-1:0]  off_ff, off_in;
   logic [15:0]    cnt_ff, cnt_in;
   logic [31:0]    hbuf_ff, hbuf_in;
   logic [15:0]    tkey_ff, tkey_in;
   logic           found_ff, found_in;
   logic [OW-1:0]  first_ff, first_in;
   logic [OW-1:0]  loff_ff, loff_in;
   logic [15:0]    llen_ff, llen_in;
   logic [SW-1:0]  wsec_ff, wsec_in;
   logic [OW-1:0]  wbase_ff, wbase_in;
   logic [15:0]    wkey_ff, wkey_in;
   logic [15:0]    wlen_ff, wlen_in;
   logic [CW-1:0]  wo_ff, wo_in;
   logic [OW-1:0]  src_ff, src_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [AW-1:0]  clr_end_ff, clr_end_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rdata_ff;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [7:0]     wr_data;
   logic [CW-1:0]  w_off, r_off;
   logic [15:0]    hkey, hlen;
   logic [CW-1:0]  off_c, rec_end;
   logic [CW-1:0]  next_c;
   logic           rec_ok;
   logic [SW-1:0]  nxt_sec;
   logic           raddr_in_sec;

   function automatic logic [AW-1:0] phys(input logic [SW-1:0] sec, input logic [CW-1:0] off);
      phys = AW'(sec) * AW'(SECTOR_BYTES) + off[AW-1:0];
   endfunction

   assign hkey    = hbuf_ff[15:0];
   assign hlen    = hbuf_ff[31:16];
   assign off_c   = CW'(off_ff);
   assign rec_end = off_c + FOUR_C + CW'(hlen);
   assign next_c  = (rec_end + CW'(3)) & ~CW'(3);
   assign rec_ok  = (off_c + FOUR_C <= SB_C) && (hkey != END_KEY) && (rec_end <= SB_C);
   assign nxt_sec = (active_ff == SW'(SECTOR_COUNT - 1)) ? '0 : active_ff + SW'(1);
   assign raddr_in_sec = CW'(rq_ff.address) < SB_C;

   always_comb begin
      rq_in        = rq_ff;
      active_in    = active_ff;
      append_in    = append_ff;
      pkey_in      = pkey_ff;
      plen_in      = plen_ff;
      brx_in       = brx_ff;
      cro_in       = cro_ff;
      cwo_in       = cwo_ff;
      cn_in        = cn_ff;
      off_in       = off_ff;
      cnt_in       = cnt_ff;
      hbuf_in      = hbuf_ff;
      tkey_in      = tkey_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      loff_in      = loff_ff;
      llen_in      = llen_ff;
      wsec_in      = wsec_ff;
      wbase_in     = wbase_ff;
      wkey_in      = wkey_ff;
      wlen_in      = wlen_ff;
      wo_in        = wo_ff;
      src_in       = src_ff;
      clr_in       = clr_ff;
      clr_end_in   = clr_end_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = ERASED;
      rd_en        = 1'b0;
      rd_addr      = '0;
      w_off        = '0;
      r_off        = '0;
      case (cmd)
         DP_LATCH: begin
            rq_in = req_item;
         end
         DP_CLR_ALL_INIT: begin
            clr_in     = '0;
            clr_end_in = AW'(TOTAL - 1);
            active_in  = '0;
            append_in  = '0;
            plen_in    = '0;
            brx_in     = '0;
         end
         DP_CLR_SEC_INIT: begin
            clr_in     = phys(active_ff, '0);
            clr_end_in = phys(active_ff, SB_C - CW'(1));
         end
         DP_CLR_STEP: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
         end
         DP_ABORT_INIT: begin
            cnt_in = '0;
         end
         DP_ABORT_STEP: begin
            w_off   = CW'(append_ff) + FOUR_C + CW'(cnt_ff);
            wr_en   = w_off < SB_C;
            wr_addr = phys(active_ff, w_off);
            cnt_in  = cnt_ff + 16'd1;
         end
         DP_ABORT_DONE: begin
            plen_in = '0;
            brx_in  = '0;
         end
         DP_PEND_LOAD: begin
            pkey_in = rq_ff.key;
            plen_in = rq_ff.length;
            brx_in  = '0;
         end
         DP_DATA_WR: begin
            w_off   = CW'(append_ff) + FOUR_C + CW'(brx_ff);
            wr_en   = w_off < SB_C;
            wr_addr = phys(active_ff, w_off);
            wr_data = rq_ff.data_byte;
            brx_in  = brx_ff + 12'd1;
         end
         DP_W_APPEND: begin
            wsec_in  = active_ff;
            wbase_in = append_ff;
            wkey_in  = pkey_ff;
            wlen_in  = 16'(plen_ff);
            wo_in    = CW'(append_ff) + FOUR_C + CW'(plen_ff);
            cnt_in   = '0;
         end
         DP_W_COMPACT: begin
            wsec_in  = nxt_sec;
            wbase_in = cwo_ff;
            wkey_in  = tkey_ff;
            wlen_in  = llen_ff;
            src_in   = loff_ff;
            wo_in    = CW'(cwo_ff) + FOUR_C + CW'(llen_ff);
            cnt_in   = '0;
         end
         DP_PAD_STEP: begin
            wr_en   = wo_ff < SB_C;
            wr_addr = phys(wsec_ff, wo_ff);
            wr_data = PAD;
            wo_in   = wo_ff + CW'(1);
         end
         DP_HWR_STEP: begin
            w_off   = CW'(wbase_ff) + CW'(cnt_ff);
            wr_en   = w_off < SB_C;
            wr_addr = phys(wsec_ff, w_off);
            case (cnt_ff[1:0])
               2'd0:    wr_data = wkey_ff[7:0];
               2'd1:    wr_data = wkey_ff[15:8];
               2'd2:    wr_data = wlen_ff[7:0];
               default: wr_data = wlen_ff[15:8];
            endcase
            cnt_in = (cnt_ff == 16'd3) ? '0 : cnt_ff + 16'd1;
         end
         DP_CPY_RD: begin
            r_off   = CW'(src_ff) + FOUR_C + CW'(cnt_ff);
            rd_en   = r_off < SB_C;
            rd_addr = phys(active_ff, r_off);
         end
         DP_CPY_WR: begin
            w_off   = CW'(wbase_ff) + FOUR_C + CW'(cnt_ff);
            wr_en   = w_off < SB_C;
            wr_addr = phys(wsec_ff, w_off);
            wr_data = rdata_ff;
            cnt_in  = cnt_ff + 16'd1;
         end
         DP_CWO_END: begin
            cwo_in = wo_ff[OW-1:0];
            cro_in = cn_ff;
            off_in = cn_ff;
            cnt_in = '0;
         end
         DP_CPT_NEXT: begin
            cro_in = cn_ff;
            off_in = cn_ff;
            cnt_in = '0;
         end
         DP_APPEND_END: begin
            append_in = wo_ff[OW-1:0];
         end
         DP_CPT_INIT: begin
            cro_in = '0;
            cwo_in = '0;
            off_in = '0;
            cnt_in = '0;
         end
         DP_CPT_REC: begin
            tkey_in  = hkey;
            cn_in    = next_c[OW-1:0];
            off_in   = '0;
            found_in = 1'b0;
            cnt_in   = '0;
         end
         DP_SCAN_INIT: begin
            tkey_in  = rq_ff.key;
            off_in   = '0;
            found_in = 1'b0;
            cnt_in   = '0;
         end
         DP_HRD_STEP: begin
            r_off   = off_c + CW'(cnt_ff);
            rd_en   = (cnt_ff < 16'd4) && (r_off < SB_C);
            rd_addr = phys(active_ff, r_off);
            case (cnt_ff[2:0])
               3'd1:    hbuf_in[7:0]   = rdata_ff;
               3'd2:    hbuf_in[15:8]  = rdata_ff;
               3'd3:    hbuf_in[23:16] = rdata_ff;
               3'd4:    hbuf_in[31:24] = rdata_ff;
               default: hbuf_in = hbuf_ff;
            endcase
            cnt_in = cnt_ff + 16'd1;
         end
         DP_SCAN_EVAL: begin
            cnt_in = '0;
            if (rec_ok) begin
               if (hkey == tkey_ff) begin
                  found_in = 1'b1;
                  if (!found_ff) begin
                     first_in = off_ff;
                  end
                  loff_in = off_ff;
                  llen_in = hlen;
               end
               off_in = next_c[OW-1:0];
            end
         end
         DP_CPT_SWITCH: begin
            active_in = nxt_sec;
            append_in = cwo_ff;
         end
         DP_RD_ISSUE: begin
            rd_en   = raddr_in_sec;
            rd_addr = phys(active_ff, CW'(rq_ff.address));
         end
         DP_RSP_READ: begin
            rsp_in       = '{STATUS_OK, 12'd0, 12'd0, raddr_in_sec ? rdata_ff : ERASED};
            rsp_valid_in = 1'b1;
         end
         DP_RSP_GET: begin
            if (found_ff) begin
               rsp_in = '{STATUS_OK, 12'(loff_ff + OW'(4)), llen_ff[11:0], 8'd0};
            end else begin
               rsp_in = '{STATUS_NOT_FOUND, 12'd0, 12'd0, 8'd0};
            end
            rsp_valid_in = 1'b1;
         end
         DP_RSP_OK: begin
            rsp_in       = '{STATUS_OK, 12'd0, 12'd0, 8'd0};
            rsp_valid_in = 1'b1;
         end
         DP_RSP_NOSPACE: begin
            rsp_in       = '{STATUS_NO_SPACE, 12'd0, 12'd0, 8'd0};
            rsp_valid_in = 1'b1;
         end
         DP_RSP_BADKEY: begin
            rsp_in       = '{STATUS_BAD_KEY, 12'd0, 12'd0, 8'd0};
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         append_ff    <= '0;
         pkey_ff      <= '0;
         plen_ff      <= '0;
         brx_ff       <= '0;
         cro_ff       <= '0;
         cwo_ff       <= '0;
         clr_ff       <= '0;
         clr_end_ff   <= AW'(TOTAL - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         append_ff    <= append_in;
         pkey_ff      <= pkey_in;
         plen_ff      <= plen_in;
         brx_ff       <= brx_in;
         cro_ff       <= cro_in;
         cwo_ff       <= cwo_in;
         clr_ff       <= clr_in;
         clr_end_ff   <= clr_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff    <= rq_in;
      cn_ff    <= cn_in;
      off_ff   <= off_in;
      cnt_ff   <= cnt_in;
      hbuf_ff  <= hbuf_in;
      tkey_ff  <= tkey_in;
      found_ff <= found_in;
      first_ff <= first_in;
      loff_ff  <= loff_in;
      llen_ff  <= llen_in;
      wsec_ff  <= wsec_in;
      wbase_ff <= wbase_in;
      wkey_ff  <= wkey_in;
      wlen_ff  <= wlen_in;
      wo_ff    <= wo_in;
      src_ff   <= src_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      st.op         = rq_ff.op;
      st.key_end    = rq_ff.key == END_KEY;
      st.data_more  = brx_ff < plen_ff;
      st.data_last  = (13'(brx_ff) + 13'd1) == 13'(plen_ff);
      st.abort_more = (brx_ff < plen_ff) && (cnt_ff < 16'(brx_ff));
      st.fits       = (CW'(append_ff) + FOUR_C + CW'(rq_ff.length)) <= SB_C;
      st.len_zero   = rq_ff.length == 12'd0;
      st.pad_more   = wo_ff[1:0] != 2'd0;
      st.cnt3       = cnt_ff == 16'd3;
      st.cnt4       = cnt_ff == 16'd4;
      st.cpy_more   = cnt_ff < wlen_ff;
      st.rec_ok     = rec_ok;
      st.keep       = found_ff && (first_ff == cro_ff);
      st.clr_last   = clr_ff == clr_end_ff;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_ALWAYS(a_brx_le_plen, clock, reset, brx_ff <= plen_ff)
endmodule

/* hdl/flkv_ctrl.sv */
// ----------------------------------------------------------------------------
// flkv_ctrl
// sequencer for scan, append, compaction and erase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flkv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  flkv_pkg::dp_status_type st,
   output flkv_pkg::dp_op_type     cmd,
   output logic                    busy
);
   import flkv_pkg::*;

   typedef enum logic [20:0] {
      ST_BOOT     = 21'h000001,
      ST_IDLE     = 21'h000002,
      ST_DISPATCH = 21'h000004,
      ST_READ     = 21'h000008,
      ST_WIPE     = 21'h000010,
      ST_RSP_OK   = 21'h000020,
      ST_ABORT    = 21'h000040,
      ST_FIT      = 21'h000080,
      ST_FIN      = 21'h000100,
      ST_PAD      = 21'h000200,
      ST_HWR      = 21'h000400,
      ST_AEND     = 21'h000800,
      ST_CPY_RD   = 21'h001000,
      ST_CPY_WR   = 21'h002000,
      ST_CPT_HRD  = 21'h004000,
      ST_CPT_REC  = 21'h008000,
      ST_HRD      = 21'h010000,
      ST_EVAL     = 21'h020000,
      ST_SCAN_END = 21'h040000,
      ST_ERASE    = 21'h080000,
      ST_SWITCH   = 21'h100000
   } state_type;

   state_type state_ff, state_in;
   logic      cpt_ff, cpt_in;
   logic      did_ff, did_in;

   always_comb begin
      state_in = state_ff;
      cpt_in   = cpt_ff;
      did_in   = did_ff;
      cmd      = DP_NOP;
      case (state_ff)
         ST_BOOT: begin
            cmd = DP_CLR_STEP;
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd      = DP_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            did_in   = 1'b0;
            state_in = ST_IDLE;
            case (st.op)
               OP_GET: begin
                  cmd      = DP_SCAN_INIT;
                  state_in = ST_HRD;
               end
               OP_SET: begin
                  if (st.key_end) begin
                     cmd = DP_RSP_BADKEY;
                  end else begin
                     cmd      = DP_ABORT_INIT;
                     state_in = ST_ABORT;
                  end
               end
               OP_DATA: begin
                  if (st.data_more) begin
                     cmd = DP_DATA_WR;
                     if (st.data_last) state_in = ST_FIN;
                  end
               end
               OP_READ: begin
                  cmd      = DP_RD_ISSUE;
                  state_in = ST_READ;
               end
               OP_WIPE: begin
                  cmd      = DP_CLR_ALL_INIT;
                  state_in = ST_WIPE;
               end
               default: begin
                  cmd = DP_NOP;
               end
            endcase
         end
         ST_READ: begin
            cmd      = DP_RSP_READ;
            state_in = ST_IDLE;
         end
         ST_WIPE: begin
            cmd = DP_CLR_STEP;
            if (st.clr_last) state_in = ST_RSP_OK;
         end
         ST_RSP_OK: begin
            cmd      = DP_RSP_OK;
            state_in = ST_IDLE;
         end
         ST_ABORT: begin
            if (st.abort_more) begin
               cmd = DP_ABORT_STEP;
            end else begin
               cmd      = DP_ABORT_DONE;
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (st.fits) begin
               cmd      = DP_PEND_LOAD;
               state_in = st.len_zero ? ST_FIN : ST_RSP_OK;
            end else if (!did_ff) begin
               cmd      = DP_CPT_INIT;
               cpt_in   = 1'b1;
               did_in   = 1'b1;
               state_in = ST_CPT_HRD;
            end else begin
               cmd      = DP_RSP_NOSPACE;
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            cmd      = DP_W_APPEND;
            state_in = ST_PAD;
         end
         ST_PAD: begin
            if (st.pad_more) begin
               cmd = DP_PAD_STEP;
            end else begin
               state_in = ST_HWR;
            end
         end
         ST_HWR: begin
            cmd = DP_HWR_STEP;
            if (st.cnt3) state_in = cpt_ff ? ST_CPY_RD : ST_AEND;
         end
         ST_AEND: begin
            cmd      = DP_APPEND_END;
            state_in = (st.op == OP_SET) ? ST_RSP_OK : ST_IDLE;
         end
         ST_CPY_RD: begin
            if (st.cpy_more) begin
               cmd      = DP_CPY_RD;
               state_in = ST_CPY_WR;
            end else begin
               cmd      = DP_CWO_END;
               state_in = ST_CPT_HRD;
            end
         end
         ST_CPY_WR: begin
            cmd      = DP_CPY_WR;
            state_in = ST_CPY_RD;
         end
         ST_CPT_HRD: begin
            cmd = DP_HRD_STEP;
            if (st.cnt4) state_in = ST_CPT_REC;
         end
         ST_CPT_REC: begin
            if (st.rec_ok) begin
               cmd      = DP_CPT_REC;
               state_in = ST_HRD;
            end else begin
               cmd      = DP_CLR_SEC_INIT;
               state_in = ST_ERASE;
            end
         end
         ST_HRD: begin
            cmd = DP_HRD_STEP;
            if (st.cnt4) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd      = DP_SCAN_EVAL;
            state_in = st.rec_ok ? ST_HRD : ST_SCAN_END;
         end
         ST_SCAN_END: begin
            if (!cpt_ff) begin
               cmd      = DP_RSP_GET;
               state_in = ST_IDLE;
            end else if (st.keep) begin
               cmd      = DP_W_COMPACT;
               state_in = ST_PAD;
            end else begin
               cmd      = DP_CPT_NEXT;
               state_in = ST_CPT_HRD;
            end
         end
         ST_ERASE: begin
            cmd = DP_CLR_STEP;
            if (st.clr_last) state_in = ST_SWITCH;
         end
         ST_SWITCH: begin
            cmd      = DP_CPT_SWITCH;
            cpt_in   = 1'b0;
            state_in = ST_FIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         cpt_ff   <= 1'b0;
         did_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cpt_ff   <= cpt_in;
         did_ff   <= did_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   `ASSERT_IMPLIES(a_idle_no_compact, clock, reset, state_ff == ST_IDLE, !cpt_ff)
endmodule

/* hdl/flash_log_key_value_store.sv */
// ----------------------------------------------------------------------------
// flash_log_key_value_store
// log-structured key-value store over erasable byte sectors with compaction
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy stays high
// until the command has finished. Ops: get, set start, set data byte, read
// stored byte, wipe. Every op but a data byte (and unused codes) answers with
// one rsp_ word, shown on rsp_item for a single cycle with rsp_strobe high;
// the receiver cannot hold it off.
// A data byte that closes a record also pads it and writes its header. A set
// start first overwrites with 0xFF the bytes already taken for a record that
// was left unfinished. A get reads the header of every record in the active
// sector. A set that needs compaction rescans the sector once per record
// (quadratic in the record count), copies each byte with a read and then a
// write, and erases one byte per cycle. The sector memory has a single
// byte-wide read port.
// After reset the memory is cleared to 0xFF one byte per cycle, with busy
// high. A wipe does the same.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flash_log_key_value_store #(
   parameter int SECTOR_BYTES = 4096,
   parameter int SECTOR_COUNT = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  flkv_pkg::req_type req_item,
   output logic              rsp_strobe,
   output flkv_pkg::rsp_type rsp_item
);
   import flkv_pkg::*;

   dp_op_type     cmd;
   dp_status_type st;

   flkv_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .cmd   (cmd),
      .busy  (busy)
   );

   flkv_datapath #(
      .SECTOR_BYTES (SECTOR_BYTES),
      .SECTOR_COUNT (SECTOR_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .st         (st),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );
endmodule
